>>> rtl/ors_pkg.sv
`timescale 1ns / 1ps

package ors_pkg;

  localparam int IdBitsDefault = 64;
  localparam int IdPortW       = 64;

  localparam logic [1:0] OpStart     = 2'd0;
  localparam logic [1:0] OpResetDone = 2'd1;
  localparam logic [1:0] OpBitPair   = 2'd2;

  localparam logic [2:0] ActReset = 3'd0;
  localparam logic [2:0] ActByte  = 3'd1;
  localparam logic [2:0] ActPair  = 3'd2;
  localparam logic [2:0] ActBit   = 3'd3;
  localparam logic [2:0] ActDone  = 3'd4;

  localparam logic [2:0] StFound  = 3'd0;
  localparam logic [2:0] StWrap   = 3'd1;
  localparam logic [2:0] StNoNext = 3'd2;
  localparam logic [2:0] StNoPres = 3'd3;
  localparam logic [2:0] StError  = 3'd4;

  localparam logic [7:0] CmdSearch = 8'hF0;
  localparam logic [7:0] CmdAlarm  = 8'hEC;

  typedef struct packed {
    logic [1:0]         op;
    logic [IdPortW-1:0] start_id;
    logic               alarm_only;
    logic               presence_ok;
    logic               id_bit;
    logic               complement_bit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         byte_value;
    logic               bit_value;
    logic [2:0]         status;
    logic [IdPortW-1:0] found_id;
    logic               last_of_run;
  } result_t;

  function automatic result_t make_result(logic [2:0] action, logic [7:0] byte_value,
                                          logic bit_value, logic [2:0] status);
    result_t r;
    r             = '0;
    r.action      = action;
    r.byte_value  = byte_value;
    r.bit_value   = bit_value;
    r.status      = status;
    return r;
  endfunction

endpackage

>>> rtl/ors_seq.sv
`timescale 1ns / 1ps

module ors_seq #(
  parameter int ID_BITS = ors_pkg::IdBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  ors_pkg::in_item_t  item_i,
  output ors_pkg::result_t   res0_o,
  output ors_pkg::result_t   res1_o,
  output logic [1:0]         res_cnt_o
);

  localparam int PosW = $clog2(ID_BITS);
  localparam logic [PosW-1:0] LastPos = PosW'(ID_BITS - 1);

  localparam logic [2:0] PhIdle      = 3'd0;
  localparam logic [2:0] PhWaitReset = 3'd1;
  localparam logic [2:0] PhPass1     = 3'd2;
  localparam logic [2:0] PhPass2     = 3'd3;
  localparam logic [2:0] PhPass3     = 3'd4;

  logic [ID_BITS-1:0] id_q, id_d;
  logic [2:0]         phase_q, phase_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               bp_vld_q, bp_vld_d;
  logic [PosW-1:0]    bp_q, bp_d;
  logic               alarm_q, alarm_d;
  logic               pass_q, pass_d;

  logic [ID_BITS-1:0] id_rev, id_rev_inc, id_adv, id_set;
  logic [1:0]         pair;
  logic               dir;
  logic               dead_end;
  logic               bpv_new;
  logic [7:0]         cmd;
  ors_pkg::result_t   r0, r1;
  logic [1:0]         n;

  always_comb begin
    for (int i = 0; i < ID_BITS; i++) begin
      id_rev[i] = id_q[ID_BITS-1-i];
    end
    id_rev_inc = id_rev + ID_BITS'(1);
    for (int i = 0; i < ID_BITS; i++) begin
      id_adv[i] = id_rev_inc[ID_BITS-1-i];
    end
  end

  always_comb begin
    id_d     = id_q;
    phase_d  = phase_q;
    pos_d    = pos_q;
    bp_vld_d = bp_vld_q;
    bp_d     = bp_q;
    alarm_d  = alarm_q;
    pass_d   = pass_q;
    r0       = '0;
    r1       = '0;
    n        = 2'd0;
    pair     = {item_i.complement_bit, item_i.id_bit};
    dir      = 1'b0;
    dead_end = 1'b0;
    bpv_new  = bp_vld_q;
    id_set   = id_q;
    cmd      = alarm_q ? ors_pkg::CmdAlarm : ors_pkg::CmdSearch;

    case (item_i.op)
      ors_pkg::OpStart: begin
        id_d     = item_i.start_id[ID_BITS-1:0];
        alarm_d  = item_i.alarm_only;
        pass_d   = 1'b0;
        bp_vld_d = 1'b0;
        pos_d    = '0;
        phase_d  = PhWaitReset;
        r0       = ors_pkg::make_result(ors_pkg::ActReset, 8'd0, 1'b0, ors_pkg::StFound);
        n        = 2'd1;
      end
      ors_pkg::OpResetDone: begin
        if (phase_q == PhWaitReset) begin
          if (!item_i.presence_ok) begin
            phase_d = PhIdle;
            r0      = ors_pkg::make_result(ors_pkg::ActDone, 8'd0, 1'b0, ors_pkg::StNoPres);
            n       = 2'd1;
          end else if (!pass_q && id_adv == '0) begin
            id_d    = '0;
            phase_d = PhIdle;
            r0      = ors_pkg::make_result(ors_pkg::ActDone, 8'd0, 1'b0, ors_pkg::StWrap);
            n       = 2'd1;
          end else begin
            if (!pass_q) begin
              id_d     = id_adv;
              bp_vld_d = 1'b0;
              phase_d  = PhPass1;
            end else begin
              phase_d  = bp_vld_q ? PhPass2 : PhPass3;
            end
            pos_d = '0;
            r0    = ors_pkg::make_result(ors_pkg::ActByte, cmd, 1'b0, ors_pkg::StFound);
            r1    = ors_pkg::make_result(ors_pkg::ActPair, 8'd0, 1'b0, ors_pkg::StFound);
            n     = 2'd2;
          end
        end
      end
      ors_pkg::OpBitPair: begin
        unique case (phase_q) inside
          PhPass1: begin
            dir = id_q[pos_q];
            r0  = ors_pkg::make_result(ors_pkg::ActBit, 8'd0, dir, ors_pkg::StFound);
            n   = 2'd2;
            if (pair == 2'b11) begin
              phase_d = PhIdle;
              r1      = ors_pkg::make_result(ors_pkg::ActDone, 8'd0, 1'b0, ors_pkg::StError);
            end else begin
              if (pair != 2'b10 && !dir) begin
                bpv_new  = 1'b1;
                bp_vld_d = 1'b1;
                bp_d     = pos_q;
              end
              dead_end = (pair == 2'b10 && dir) || (pair == 2'b01 && !dir);
              if (dead_end) begin
                if (!bpv_new) begin
                  phase_d = PhIdle;
                  r1 = ors_pkg::make_result(ors_pkg::ActDone, 8'd0, 1'b0, ors_pkg::StNoNext);
                end else begin
                  pass_d  = 1'b1;
                  phase_d = PhWaitReset;
                  r1 = ors_pkg::make_result(ors_pkg::ActReset, 8'd0, 1'b0, ors_pkg::StFound);
                end
              end else if (pos_q == LastPos) begin
                phase_d = PhIdle;
                r1 = ors_pkg::make_result(ors_pkg::ActDone, 8'd0, 1'b0, ors_pkg::StFound);
              end else begin
                pos_d = pos_q + PosW'(1);
                r1 = ors_pkg::make_result(ors_pkg::ActPair, 8'd0, 1'b0, ors_pkg::StFound);
              end
            end
          end
          PhPass2, PhPass3: begin
            if (phase_q == PhPass3 && pair == 2'b11) begin
              phase_d = PhIdle;
              r0 = ors_pkg::make_result(ors_pkg::ActDone, 8'd0, 1'b0, ors_pkg::StError);
              n  = 2'd1;
            end else begin
              if (phase_q == PhPass2) begin
                if (pos_q == bp_q) begin
                  id_set[pos_q] = 1'b1;
                end
              end else begin
                id_set[pos_q] = (pair == 2'b01);
              end
              id_d = id_set;
              dir  = id_set[pos_q];
              r0   = ors_pkg::make_result(ors_pkg::ActBit, 8'd0, dir, ors_pkg::StFound);
              n    = 2'd2;
              if (pos_q == LastPos) begin
                phase_d = PhIdle;
                r1 = ors_pkg::make_result(ors_pkg::ActDone, 8'd0, 1'b0, ors_pkg::StFound);
              end else begin
                pos_d = pos_q + PosW'(1);
                if (phase_q == PhPass2 && pos_q >= bp_q) begin
                  phase_d = PhPass3;
                end
                r1 = ors_pkg::make_result(ors_pkg::ActPair, 8'd0, 1'b0, ors_pkg::StFound);
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (r0.action == ors_pkg::ActDone) begin
      r0.found_id = ors_pkg::IdPortW'(id_d);
    end
    if (r1.action == ors_pkg::ActDone) begin
      r1.found_id = ors_pkg::IdPortW'(id_d);
    end
    if (n == 2'd2) begin
      r1.last_of_run = 1'b1;
    end else if (n == 2'd1) begin
      r0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q     <= '0;
      phase_q  <= PhIdle;
      pos_q    <= '0;
      bp_vld_q <= 1'b0;
      bp_q     <= '0;
      alarm_q  <= 1'b0;
      pass_q   <= 1'b0;
    end else if (step_i) begin
      id_q     <= id_d;
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      bp_vld_q <= bp_vld_d;
      bp_q     <= bp_d;
      alarm_q  <= alarm_d;
      pass_q   <= pass_d;
    end
  end

  assign res0_o    = r0;
  assign res1_o    = r1;
  assign res_cnt_o = step_i ? n : 2'd0;

endmodule

>>> rtl/ors_result_fifo.sv
`timescale 1ns / 1ps

module ors_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       wr_cnt_i,
  input  ors_pkg::result_t wr0_i,
  input  ors_pkg::result_t wr1_i,
  output logic             room2_o,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output ors_pkg::result_t rd_data_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  ors_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    count_q, count_d;
  logic [PtrW-1:0]  wr_ptr_nxt;
  logic             pop;

  assign pop        = rd_valid_o && rd_ready_i;
  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);
  assign wr_ptr_d   = wr_ptr_q + PtrW'(wr_cnt_i);
  assign rd_ptr_d   = rd_ptr_q + PtrW'(pop);
  assign count_d    = count_q + (PtrW + 1)'(wr_cnt_i) - (PtrW + 1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wr0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= wr1_i;
    end
  end

  assign room2_o    = count_q <= (PtrW + 1)'(Depth - 2);
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];

endmodule

>>> rtl/onewire_rom_search_unit.sv
`timescale 1ns / 1ps

// This block steps a 1-Wire master through a Search ROM or Alarm Search to find the
// device that follows a given ID in search order. The input channel carries one
// transaction per event: a start request with the previous ID, a finished bus reset
// with its presence flag, or a received id and complement bit pair. The output channel
// carries the bus actions to perform and, at the end, a done transaction with status
// and the found ID. Each input transaction yields zero, one or two output transactions,
// and the last of them is flagged by last_of_run.
// An accepted transaction is held in an input register and evaluated once the result queue
// has room for two entries; its output transactions are written to that queue, and a second
// one follows the first in the next cycle when the receiver is ready.
// A new input transaction can be accepted in every cycle while the result queue has room
// for two entries; the throughput is bounded by the output channel at one transaction per
// cycle, fed from a four-entry result queue. When the receiver stalls, the queue fills and
// in_ready_o drops once fewer than two entries are free; nothing is lost or reordered.
// Reset clears the sequencer to idle with a zero ID, no branch recorded and an empty
// result queue.

module onewire_rom_search_unit #(
  parameter int ID_BITS = ors_pkg::IdBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] start_id_i,
  input  logic        alarm_only_i,
  input  logic        presence_ok_i,
  input  logic        id_bit_i,
  input  logic        complement_bit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic [7:0]  byte_value_o,
  output logic        bit_value_o,
  output logic [2:0]  status_o,
  output logic [63:0] found_id_o,
  output logic        last_of_run_o
);

  ors_pkg::in_item_t item_q;
  logic              item_vld_q, item_vld_d;
  logic              accept;
  logic              step;
  logic              room2;
  ors_pkg::result_t  res0, res1, rd_data;
  logic [1:0]        res_cnt;

  assign step       = item_vld_q && room2;
  assign in_ready_o = !item_vld_q || step;
  assign accept     = in_valid_i && in_ready_o;
  assign item_vld_d = accept ? 1'b1 : (step ? 1'b0 : item_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op             <= op_i;
      item_q.start_id       <= start_id_i;
      item_q.alarm_only     <= alarm_only_i;
      item_q.presence_ok    <= presence_ok_i;
      item_q.id_bit         <= id_bit_i;
      item_q.complement_bit <= complement_bit_i;
    end
  end

  ors_seq #(
    .ID_BITS(ID_BITS)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .res0_o   (res0),
    .res1_o   (res1),
    .res_cnt_o(res_cnt)
  );

  ors_result_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_cnt_i  (res_cnt),
    .wr0_i     (res0),
    .wr1_i     (res1),
    .room2_o   (room2),
    .rd_valid_o(out_valid_o),
    .rd_ready_i(out_ready_i),
    .rd_data_o (rd_data)
  );

  assign action_o      = rd_data.action;
  assign byte_value_o  = rd_data.byte_value;
  assign bit_value_o   = rd_data.bit_value;
  assign status_o      = rd_data.status;
  assign found_id_o    = rd_data.found_id;
  assign last_of_run_o = rd_data.last_of_run;

endmodule

>>> tb/onewire_rom_search_checker.sv
`timescale 1ns / 1ps

module onewire_rom_search_checker #(
  parameter int ID_BITS = ors_pkg::IdBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  op_i,
  input  logic [63:0] start_id_i,
  input  logic        alarm_only_i,
  input  logic        presence_ok_i,
  input  logic        id_bit_i,
  input  logic        complement_bit_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  action_i,
  input  logic [7:0]  byte_value_i,
  input  logic        bit_value_i,
  input  logic [2:0]  status_i,
  input  logic [63:0] found_id_i,
  input  logic        last_of_run_i,
  output int          fail_count_o,
  output int          outstanding_o
);

  // A bit pair is {complement slot, id slot}.
  localparam logic [1:0] PairOnlyOne  = 2'b01;
  localparam logic [1:0] PairOnlyZero = 2'b10;
  localparam logic [1:0] PairBothOne  = 2'b11;

  localparam logic [63:0] IdMask = (ID_BITS >= 64) ? {64{1'b1}} :
                                   ((64'd1 << ID_BITS) - 64'd1);

  typedef enum logic [2:0] {
    SeqIdle,
    SeqWaitReset,
    SeqPass1,
    SeqPass2,
    SeqPass3
  } search_phase_e;

  logic [63:0]       dev_id       = '0;
  search_phase_e     seq_phase    = SeqIdle;
  int unsigned       bit_pos      = 0;
  int                branch_at    = -1;
  logic              alarm_mode   = 1'b0;
  logic              second_pass  = 1'b0;
  ors_pkg::result_t  step_results[$];
  ors_pkg::result_t  expected_results[$];
  int                mismatch_count = 0;

  function automatic logic [63:0] next_in_search_order(logic [63:0] id);
    logic carry;
    carry = 1'b1;
    for (int b = ID_BITS - 1; b >= 0; b--) begin
      if (carry) begin
        carry = id[b];
        id[b] = ~id[b];
      end
    end
    return id;
  endfunction

  function automatic void emit(logic [2:0] act, logic [7:0] cmd, logic dir);
    ors_pkg::result_t r;
    r            = '0;
    r.action     = act;
    r.byte_value = cmd;
    r.bit_value  = dir;
    step_results.push_back(r);
  endfunction

  function automatic void finish_search(logic [2:0] st);
    ors_pkg::result_t r;
    r          = '0;
    r.action   = ors_pkg::ActDone;
    r.status   = st;
    r.found_id = dev_id;
    step_results.push_back(r);
    seq_phase = SeqIdle;
  endfunction

  function automatic void predict_search_step();
    int unsigned      k;
    logic             dir;
    logic [1:0]       pair;
    ors_pkg::result_t r;
    k    = bit_pos;
    pair = {complement_bit_i, id_bit_i};
    case (op_i)
      ors_pkg::OpStart: begin
        dev_id      = start_id_i & IdMask;
        alarm_mode  = alarm_only_i;
        second_pass = 1'b0;
        branch_at   = -1;
        bit_pos     = 0;
        seq_phase   = SeqWaitReset;
        emit(ors_pkg::ActReset, '0, 1'b0);
      end
      ors_pkg::OpResetDone: begin
        if (seq_phase == SeqWaitReset) begin
          if (!presence_ok_i) begin
            finish_search(ors_pkg::StNoPres);
          end else begin
            if (!second_pass) begin
              dev_id = next_in_search_order(dev_id);
              if (dev_id == '0) begin
                finish_search(ors_pkg::StWrap);
              end else begin
                branch_at = -1;
                seq_phase = SeqPass1;
              end
            end else begin
              seq_phase = (branch_at < 0) ? SeqPass3 : SeqPass2;
            end
            if (seq_phase != SeqIdle) begin
              bit_pos = 0;
              emit(ors_pkg::ActByte, alarm_mode ? ors_pkg::CmdAlarm : ors_pkg::CmdSearch,
                   1'b0);
              emit(ors_pkg::ActPair, '0, 1'b0);
            end
          end
        end
      end
      ors_pkg::OpBitPair: begin
        case (seq_phase)
          SeqPass1: begin
            dir = dev_id[k];
            emit(ors_pkg::ActBit, '0, dir);
            if (pair == PairBothOne) begin
              finish_search(ors_pkg::StError);
            end else begin
              if (!pair[1] && !dir) branch_at = int'(k);
              if ((pair == PairOnlyZero && dir) || (pair == PairOnlyOne && !dir)) begin
                if (branch_at < 0) begin
                  finish_search(ors_pkg::StNoNext);
                end else begin
                  second_pass = 1'b1;
                  seq_phase   = SeqWaitReset;
                  emit(ors_pkg::ActReset, '0, 1'b0);
                end
              end else if (k + 1 >= ID_BITS) begin
                finish_search(ors_pkg::StFound);
              end else begin
                bit_pos = k + 1;
                emit(ors_pkg::ActPair, '0, 1'b0);
              end
            end
          end
          SeqPass2: begin
            if (int'(k) == branch_at) dev_id[k] = 1'b1;
            emit(ors_pkg::ActBit, '0, dev_id[k]);
            if (k + 1 >= ID_BITS) begin
              finish_search(ors_pkg::StFound);
            end else begin
              bit_pos = k + 1;
              if (int'(k + 1) > branch_at) seq_phase = SeqPass3;
              emit(ors_pkg::ActPair, '0, 1'b0);
            end
          end
          SeqPass3: begin
            if (pair == PairBothOne) begin
              finish_search(ors_pkg::StError);
            end else begin
              dev_id[k] = (pair == PairOnlyOne);
              emit(ors_pkg::ActBit, '0, dev_id[k]);
              if (k + 1 >= ID_BITS) begin
                finish_search(ors_pkg::StFound);
              end else begin
                bit_pos = k + 1;
                emit(ors_pkg::ActPair, '0, 1'b0);
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (step_results.size() != 0) begin
      r = step_results.pop_back();
      r.last_of_run = 1'b1;
      step_results.push_back(r);
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
      step_results.delete();
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_result();
    ors_pkg::result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected, action %0d", action_i));
    end else begin
      want = expected_results.pop_front();
      if (action_i !== want.action)
        report_mismatch($sformatf("action %0d, expected %0d", action_i, want.action));
      if (byte_value_i !== want.byte_value)
        report_mismatch($sformatf("byte_value %h, expected %h", byte_value_i,
                                  want.byte_value));
      if (bit_value_i !== want.bit_value)
        report_mismatch($sformatf("bit_value %b, expected %b", bit_value_i,
                                  want.bit_value));
      if (status_i !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", status_i, want.status));
      if (found_id_i !== want.found_id)
        report_mismatch($sformatf("found_id %h, expected %h", found_id_i, want.found_id));
      if (last_of_run_i !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %b, expected %b", last_of_run_i,
                                  want.last_of_run));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_id      = '0;
      seq_phase   = SeqIdle;
      bit_pos     = 0;
      branch_at   = -1;
      alarm_mode  = 1'b0;
      second_pass = 1'b0;
      expected_results.delete();
      outstanding_o <= 0;
      fail_count_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) predict_search_step();
      outstanding_o <= expected_results.size();
      fail_count_o  <= mismatch_count;
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] OpUnused   = 2'd3;
  localparam int         ItemTarget = 1400;
  localparam int         QuietLimit = 4000;

  typedef struct packed {
    logic [2:0] action;
    logic       bit_value;
  } bus_req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [63:0] start_id_i;
  logic        alarm_only_i;
  logic        presence_ok_i;
  logic        id_bit_i;
  logic        complement_bit_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  action_o;
  logic [7:0]  byte_value_o;
  logic        bit_value_o;
  logic [2:0]  status_o;
  logic [63:0] found_id_o;
  logic        last_of_run_o;

  int       fail_count;
  int       outstanding;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       items_sent = 0;
  int       quiet_cycles = 0;
  bus_req_t bus_requests[$];

  onewire_rom_search_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .start_id_i       (start_id_i),
    .alarm_only_i     (alarm_only_i),
    .presence_ok_i    (presence_ok_i),
    .id_bit_i         (id_bit_i),
    .complement_bit_i (complement_bit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .action_o         (action_o),
    .byte_value_o     (byte_value_o),
    .bit_value_o      (bit_value_o),
    .status_o         (status_o),
    .found_id_o       (found_id_o),
    .last_of_run_o    (last_of_run_o)
  );

  onewire_rom_search_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .op_i             (op_i),
    .start_id_i       (start_id_i),
    .alarm_only_i     (alarm_only_i),
    .presence_ok_i    (presence_ok_i),
    .id_bit_i         (id_bit_i),
    .complement_bit_i (complement_bit_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .action_i         (action_o),
    .byte_value_i     (byte_value_o),
    .bit_value_i      (bit_value_o),
    .status_i         (status_o),
    .found_id_i       (found_id_o),
    .last_of_run_i    (last_of_run_o),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("onewire_rom_search_unit verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [63:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic ors_pkg::in_item_t make_item(logic [1:0] op, logic [63:0] sid,
                                                  logic alarm, logic pres, logic idb,
                                                  logic cb);
    ors_pkg::in_item_t it;
    it.op             = op;
    it.start_id       = sid;
    it.alarm_only     = alarm;
    it.presence_ok    = pres;
    it.id_bit         = idb;
    it.complement_bit = cb;
    return it;
  endfunction

  // Signals are looked at right after the edge, so they still hold their pre-edge values.
  task automatic tick();
    @(posedge clk_i);
    if (out_valid_o && out_ready_i) bus_requests.push_back({action_o, bit_value_o});
  endtask

  task automatic send(ors_pkg::in_item_t it, bit counts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      tick();
    end
    in_valid_i       <= 1'b1;
    op_i             <= it.op;
    start_id_i       <= it.start_id;
    alarm_only_i     <= it.alarm_only;
    presence_ok_i    <= it.presence_ok;
    id_bit_i         <= it.id_bit;
    complement_bit_i <= it.complement_bit;
    do tick(); while (!in_ready_o);
    if (counts) items_sent++;
  endtask

  task automatic next_request(output bus_req_t r);
    while (bus_requests.size() == 0) begin
      in_valid_i <= 1'b0;
      tick();
    end
    r = bus_requests.pop_front();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do tick(); while (outstanding != 0);
    bus_requests.delete();
  endtask

  // Bus model: the answering devices drive the read slots as a wired AND and drop out
  // when the master sends a direction bit that differs from their own ID bit.
  task automatic run_search();
    logic [63:0] answering[$];
    logic [63:0] alive[$];
    logic [63:0] survivors[$];
    logic [63:0] base;
    logic [63:0] dev;
    logic [63:0] sid;
    logic        alarm;
    logic        any0;
    logic        any1;
    logic        idb;
    logic        cb;
    logic        pres;
    int          pick;
    int          k;
    int          steps;
    bit          done;
    bus_req_t    r;
    alarm = ($urandom_range(3) == 0);
    base  = rand_id();
    sid   = rand_id();
    repeat ($urandom_range(6, 1)) begin
      if ($urandom_range(9) < 7) dev = base ^ (rand_id() & rand_id() & rand_id() & rand_id());
      else dev = rand_id();
      if (!alarm || $urandom_range(1)) answering.push_back(dev);
      if ($urandom_range(1)) sid = dev;
    end
    pick = $urandom_range(99);
    if (pick >= 70 && pick < 80) sid = rand_id();
    else if (pick >= 80 && pick < 90) sid = '0;
    else if (pick >= 90 && pick < 94) sid = '1;
    else if (pick >= 94) sid = base;
    send(make_item(ors_pkg::OpStart, sid, alarm, rand_bit(), rand_bit(), rand_bit()), 1'b1);
    k     = 0;
    steps = 0;
    done  = 0;
    while (!done && steps < 400) begin
      next_request(r);
      steps++;
      case (r.action)
        ors_pkg::ActReset: begin
          alive = answering;
          k     = 0;
          if ($urandom_range(99) < 3)
            send(make_item(ors_pkg::OpBitPair, rand_id(), rand_bit(), rand_bit(),
                           rand_bit(), rand_bit()), 1'b0);
          if (answering.size() != 0) pres = ($urandom_range(19) != 0);
          else pres = rand_bit();
          send(make_item(ors_pkg::OpResetDone, rand_id(), rand_bit(), pres,
                         rand_bit(), rand_bit()), 1'b1);
        end
        ors_pkg::ActPair: begin
          any0 = 1'b0;
          any1 = 1'b0;
          foreach (alive[i]) begin
            if (alive[i][k]) any1 = 1'b1;
            else any0 = 1'b1;
          end
          idb = !any0;
          cb  = !any1;
          if ($urandom_range(19) == 0) begin
            idb = rand_bit();
            cb  = rand_bit();
          end
          pick = $urandom_range(199);
          if (pick < 6)
            send(make_item(ors_pkg::OpResetDone, rand_id(), rand_bit(), rand_bit(),
                           rand_bit(), rand_bit()), 1'b0);
          else if (pick < 9)
            send(make_item(OpUnused, rand_id(), rand_bit(), rand_bit(),
                           rand_bit(), rand_bit()), 1'b0);
          else if (pick == 9)
            send(make_item(ors_pkg::OpStart, sid, alarm, rand_bit(), rand_bit(),
                           rand_bit()), 1'b1);
          send(make_item(ors_pkg::OpBitPair, rand_id(), rand_bit(), rand_bit(),
                         idb, cb), 1'b1);
        end
        ors_pkg::ActBit: begin
          survivors.delete();
          foreach (alive[i]) if (alive[i][k] == r.bit_value) survivors.push_back(alive[i]);
          alive = survivors;
          if (k < 63) k++;
        end
        ors_pkg::ActDone: done = 1;
        default: ;
      endcase
    end
    drain();
  endtask

  task automatic send_noise();
    logic [1:0] op;
    repeat ($urandom_range(4, 1)) begin
      op = 2'($urandom_range(3));
      send(make_item(op, rand_id(), rand_bit(), rand_bit(), rand_bit(), rand_bit()),
           op != OpUnused);
    end
    drain();
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       <= 1'b0;
    op_i             <= ors_pkg::OpStart;
    start_id_i       <= '0;
    alarm_only_i     <= 1'b0;
    presence_ok_i    <= 1'b0;
    id_bit_i         <= 1'b0;
    complement_bit_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    tick();

    send(make_item(ors_pkg::OpResetDone, rand_id(), 1'b0, 1'b1, 1'b0, 1'b0), 1'b0);
    send(make_item(ors_pkg::OpBitPair, rand_id(), 1'b1, 1'b0, 1'b1, 1'b0), 1'b0);
    send(make_item(OpUnused, rand_id(), 1'b1, 1'b1, 1'b1, 1'b1), 1'b0);
    send(make_item(ors_pkg::OpStart, '1, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpResetDone, '0, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpStart, rand_id(), 1'b1, 1'b1, 1'b1, 1'b1), 1'b1);
    send(make_item(ors_pkg::OpResetDone, '1, 1'b1, 1'b0, 1'b1, 1'b1), 1'b1);
    send(make_item(ors_pkg::OpStart, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, 1'b0, 1'b0),
         1'b1);
    send(make_item(ors_pkg::OpResetDone, '0, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpBitPair, '0, 1'b0, 1'b0, 1'b0, 1'b1), 1'b1);
    send(make_item(ors_pkg::OpStart, '0, 1'b1, 1'b0, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpResetDone, '0, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpBitPair, '0, 1'b0, 1'b0, 1'b1, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpResetDone, '0, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpBitPair, '0, 1'b0, 1'b0, 1'b1, 1'b1), 1'b1);
    send(make_item(ors_pkg::OpBitPair, '0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpBitPair, '0, 1'b0, 1'b0, 1'b1, 1'b1), 1'b1);
    send(make_item(ors_pkg::OpStart, rand_id(), 1'b0, 1'b0, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpResetDone, '0, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpStart, '0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpResetDone, '0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpStart, rand_id(), 1'b0, 1'b0, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpResetDone, '0, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1);
    send(make_item(ors_pkg::OpBitPair, '0, 1'b0, 1'b0, 1'b1, 1'b1), 1'b1);
    drain();

    while (items_sent < ItemTarget) begin
      case (items_sent * 4 / ItemTarget)
        0: begin
          send_idle_pct = 0;
          stall_pct     <= 0;
        end
        1: begin
          send_idle_pct = 68;
          stall_pct     <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     <= 68;
        end
        default: begin
          send_idle_pct = 21;
          stall_pct     <= 21;
        end
      endcase
      if ($urandom_range(99) < 15) send_noise();
      else run_search();
    end

    drain();
    repeat (20) tick();
    if (fail_count == 0 && outstanding == 0) begin
      $display("onewire_rom_search_unit verification clean");
    end else begin
      $display("onewire_rom_search_unit verification failed");
    end
    $finish;
  end

endmodule
